// File: hdl/egbw_pkg.sv
// Shared types, constants and helper functions for the Exp-Golomb bit writer.
// No dependencies; the top level, controller, datapath and testbench import this package.
package egbw_pkg;

    // Exp-Golomb code numbers are clamped to fit this many bits
    localparam int UE_WIDTH = 32;
    // width of the code-number path through the normaliser (code + 1 always fits)
    localparam int V_W      = 32;
    localparam int WORD_W   = 64;
    localparam int REM_W    = 7;

    localparam logic [WORD_W-1:0] UE_MAX = WORD_W'((64'd1 << UE_WIDTH) - 64'd2);
    localparam logic [WORD_W-1:0] SE_MAX = WORD_W'((64'd1 << (UE_WIDTH - 1)) - 64'd1);
    localparam logic [7:0]        BYTE_MASK = 8'hFF;

    // configuration register indexes
    localparam logic REG_WORD_ORDER = 1'b0;

    typedef enum logic [2:0] {
        CMD_BITS  = 3'd0,
        CMD_UE    = 3'd1,
        CMD_SE    = 3'd2,
        CMD_BYTE  = 3'd3,
        CMD_WORD2 = 3'd4,
        CMD_WORD4 = 3'd5,
        CMD_WORD8 = 3'd6,
        CMD_ALIGN = 3'd7
    } egbw_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PREP = 2'd1,
        ST_NORM = 2'd2,
        ST_PACK = 2'd3
    } egbw_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic norm;
        logic finish;
        logic step;
    } egbw_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic norm_done;
        logic rem_zero;
        logic out_free;
    } egbw_sts_t;

    function automatic logic [WORD_W-1:0] bswap64(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*(7-i) +: 8] = w[8*i +: 8];
        end
        return r;
    endfunction

    // leading zeros of a non-zero byte
    function automatic logic [2:0] lzc8(input logic [7:0] b);
        logic [2:0] n;
        logic       found;
        n     = 3'd0;
        found = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!found && b[i]) begin
                found = 1'b1;
                n     = 3'(7 - i);
            end
        end
        return n;
    endfunction

endpackage

// File: hdl/exp_golomb_bit_writer.sv
// Top level of the Exp-Golomb bit writer: configuration register and APB port.
// Depends on egbw_pkg, egbw_ctrl and egbw_dp.
//
// Usage:
//   Input channel (in_valid/in_stall): one request carries command, value and
//   bit_count. Commands write raw bits, unsigned or signed Exp-Golomb codes,
//   one byte, 2/4/8-byte words in the configured byte order, or zero padding to
//   the next byte boundary. Bits are packed MSB first into a partial byte.
//   Output channel (out_valid/out_stall): one completed byte per transfer;
//   last_of_run marks the final byte a command produced (none if no byte
//   completes). A byte register sits on the output side.
//   Packing: a command is packed in steps, one step per cycle while the output
//   is free, a step ending at each byte boundary (up to 9 steps for 64 bits).
//   Exp-Golomb commands first pass through the normaliser, which skips one
//   leading zero byte of the code number per cycle. in_stall is high from
//   acceptance until the request is fully packed.
//   Stalls: while out_stall holds a byte, packing halts and the byte is held.
//   Reset clears the partial byte, fill count, word_order and the pipeline.
//   word_order (address 0, bit 0): 0 little endian, 1 big endian; write idle.
module exp_golomb_bit_writer
    import egbw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic signed [63:0] value,
    input  logic [6:0]         bit_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               last_of_run
);

    logic      word_order_reg, word_order_next;
    logic      reg_sel;
    egbw_ctl_t ctl;
    egbw_sts_t sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_WORD_ORDER);

    always_comb
    begin
        word_order_next = word_order_reg;
        if (psel && penable && pwrite && pready && reg_sel)
            word_order_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_order_reg <= 1'b0;
        end
        else
        begin
            word_order_reg <= word_order_next;
        end
    end

    assign prdata = reg_sel ? {31'd0, word_order_reg} : 32'd0;

    egbw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .sts      (sts),
        .ctl      (ctl),
        .in_stall (in_stall)
    );

    egbw_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .word_order  (word_order_reg),
        .command     (command),
        .value       (value),
        .bit_count   (bit_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

// File: hdl/egbw_ctrl.sv
// Sequencing controller for the Exp-Golomb bit writer.
// Depends on egbw_pkg; drives the datapath egbw_dp through egbw_ctl_t.
module egbw_ctrl
    import egbw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [2:0]  command,
    input  egbw_sts_t   sts,
    output egbw_ctl_t   ctl,
    output logic        in_stall
);

    egbw_state_t state_reg;
    egbw_state_t state_next;
    egbw_cmd_t   cmd;

    assign cmd = egbw_cmd_t'(command);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    if (cmd == CMD_UE || cmd == CMD_SE)
                        state_next = ST_PREP;
                    else
                        state_next = ST_PACK;
                end
            end
            ST_PREP:
            begin
                ctl.prep   = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // skip leading zero bytes, then build the code word
                if (sts.norm_done)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_PACK;
                end
                else
                begin
                    ctl.norm = 1'b1;
                end
            end
            ST_PACK:
            begin
                if (sts.rem_zero)
                    state_next = ST_IDLE;
                else if (sts.out_free)
                    ctl.step = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/egbw_dp.sv
// Datapath of the Exp-Golomb bit writer: operand shaping, normaliser,
// bit packer and output register. Depends on egbw_pkg; controlled by egbw_ctrl.
module egbw_dp
    import egbw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  egbw_ctl_t          ctl,
    output egbw_sts_t          sts,
    input  logic               word_order,
    input  logic [2:0]         command,
    input  logic signed [63:0] value,
    input  logic [6:0]         bit_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               last_of_run
);

    logic [WORD_W-1:0] word_reg, word_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [7:0]        partial_reg, partial_next;
    logic [2:0]        filled_reg, filled_next;
    logic [V_W-1:0]    v_reg, v_next;
    logic [4:0]        lz_reg, lz_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              last_reg, last_next;

    egbw_cmd_t         cmd;
    logic [WORD_W-1:0] uval;
    logic              neg;
    logic [REM_W-1:0]  cnt_sat;
    logic [WORD_W-1:0] pos_m, neg_mag, neg_m;
    logic [V_W-1:0]    ue_code, se_code;
    logic [WORD_W-1:0] load_word;
    logic [REM_W-1:0]  load_rem;
    logic [2:0]        top_lz;
    logic [4:0]        lz_tot;
    logic [V_W-1:0]    v_norm;
    logic [3:0]        avail, take;
    logic [7:0]        chunk, packed_byte;
    logic [3:0]        fill_sum;
    logic [REM_W-1:0]  rem_after;
    logic              out_taken;

    assign cmd       = egbw_cmd_t'(command);
    assign uval      = unsigned'(value);
    assign neg       = value[63];
    assign out_taken = out_valid_reg && !out_stall;

    // operand shaping for a new request
    always_comb
    begin
        cnt_sat = (bit_count > 7'd64) ? 7'd64 : bit_count;
        ue_code = neg ? '0 : ((uval > UE_MAX) ? UE_MAX[V_W-1:0] : uval[V_W-1:0]);
        pos_m   = (uval > SE_MAX) ? SE_MAX : uval;
        neg_mag = ~uval + 64'd1;
        neg_m   = (neg_mag > SE_MAX) ? SE_MAX : neg_mag;
        if (neg)
            se_code = {neg_m[V_W-2:0], 1'b0};
        else if (pos_m == '0)
            se_code = '0;
        else
            se_code = {pos_m[V_W-2:0], 1'b0} - V_W'(1);

        load_word = '0;
        load_rem  = '0;
        case (cmd)
            CMD_BITS:
            begin
                if (cnt_sat != '0)
                    load_word = uval << 6'(7'd64 - cnt_sat);
                load_rem = cnt_sat;
            end
            CMD_BYTE:
            begin
                load_word = {uval[7:0] & BYTE_MASK, 56'd0};
                load_rem  = 7'd8;
            end
            CMD_WORD2:
            begin
                load_word = word_order ? (uval << 48) : bswap64(uval);
                load_rem  = 7'd16;
            end
            CMD_WORD4:
            begin
                load_word = word_order ? (uval << 32) : bswap64(uval);
                load_rem  = 7'd32;
            end
            CMD_WORD8:
            begin
                load_word = word_order ? uval : bswap64(uval);
                load_rem  = 7'd64;
            end
            CMD_ALIGN:
            begin
                load_rem = (filled_reg == 3'd0) ? 7'd0 : 7'(4'd8 - {1'b0, filled_reg});
            end
            default:
            begin
                // code numbers go through the normaliser first
                load_rem = '0;
            end
        endcase
    end

    // normaliser and code word assembly
    always_comb
    begin
        top_lz = lzc8(v_reg[V_W-1 -: 8]);
        lz_tot = lz_reg + 5'(top_lz);
        v_norm = v_reg << top_lz;
    end

    // bit packer: move as many bits as fit in the partial byte
    always_comb
    begin
        avail       = 4'd8 - {1'b0, filled_reg};
        take        = (rem_reg < 7'(avail)) ? rem_reg[3:0] : avail;
        chunk       = word_reg[WORD_W-1 -: 8] & ~(8'hFF >> take);
        packed_byte = partial_reg | (chunk >> filled_reg);
        fill_sum    = {1'b0, filled_reg} + take;
        rem_after   = rem_reg - 7'(take);
    end

    always_comb
    begin
        word_next      = word_reg;
        rem_next       = rem_reg;
        partial_next   = partial_reg;
        filled_next    = filled_reg;
        v_next         = v_reg;
        lz_next        = lz_reg;
        out_valid_next = out_taken ? 1'b0 : out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;

        if (ctl.load)
        begin
            word_next = load_word;
            rem_next  = load_rem;
            v_next    = (cmd == CMD_SE) ? se_code : ue_code;
        end
        if (ctl.prep)
        begin
            v_next  = v_reg + V_W'(1);
            lz_next = '0;
        end
        if (ctl.norm)
        begin
            v_next  = v_reg << 8;
            lz_next = lz_reg + 5'd8;
        end
        if (ctl.finish)
        begin
            word_next = {v_norm, {(WORD_W-V_W){1'b0}}} >> (5'd31 - lz_tot);
            rem_next  = 7'd63 - {1'b0, lz_tot, 1'b0};
        end
        if (ctl.step)
        begin
            word_next = word_reg << take;
            rem_next  = rem_after;
            if (fill_sum == 4'd8)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = packed_byte;
                // last completed byte when what remains cannot fill another
                last_next      = (rem_after < 7'd8);
                partial_next   = '0;
                filled_next    = '0;
            end
            else
            begin
                partial_next = packed_byte;
                filled_next  = fill_sum[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            partial_reg   <= '0;
            filled_reg    <= '0;
            lz_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            partial_reg   <= partial_next;
            filled_reg    <= filled_next;
            lz_reg        <= lz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        v_reg        <= v_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign sts.norm_done = (v_reg[V_W-1 -: 8] != 8'd0);
    assign sts.rem_zero  = (rem_reg == '0);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

// File: hdl/egbw_checker.sv
// Port-level checks for the Exp-Golomb bit writer, bound to the top level.
// Depends only on the ports of exp_golomb_bit_writer.
module egbw_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [2:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [7:0]         out_byte,
    input logic               last_of_run
);

    // hold the request window closed while a request is packed
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while previous one still packing");

    // a new byte only appears while a request is in flight
    a_byte_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output byte without a request in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte)
                                      && $stable(last_of_run)))
        else $error("stalled output byte changed");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && !paddr[2])
            |=> (paddr[2] || prdata[0] == $past(pwdata[0])))
        else $error("word_order readback differs from last write");

endmodule

bind exp_golomb_bit_writer egbw_checker u_egbw_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for exp_golomb_bit_writer: directed and random commands,
// byte-by-byte comparison against an internal bit-packing predictor.
// Depends on egbw_pkg and the exp_golomb_bit_writer RTL.
module tb
    import egbw_pkg::*;
();

    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        egbw_cmd_t  op;
        logic [63:0] operand;
        logic [6:0]  nbits;
    } bw_cmd_t;

    typedef struct {
        logic [7:0] data;
        logic       is_last;
    } out_byte_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         command = '0;
    logic signed [63:0] value = '0;
    logic [6:0]         bit_count = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         out_byte;
    logic               last_of_run;

    exp_golomb_bit_writer dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .value(value), .bit_count(bit_count),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .last_of_run(last_of_run)
    );

    always #4 clk = ~clk;

    bw_cmd_t    pending_cmds[$];
    out_byte_t  expected_bytes[$];
    logic [7:0] fresh_bytes[$];
    bw_cmd_t    drv_cmd;
    logic       in_fire = 1'b0;
    logic       no_idle = 1'b0;
    int         rx_hold_reqs = 0;
    int         rx_hold_served = 0;
    int         hold_left = 0;
    int         idle_cycles = 0;
    int         errors = 0;

    // predictor state
    logic       cfg_order = 1'b0;
    logic [7:0] pred_partial = '0;
    int         pred_fill = 0;

    function void put_bits(input logic [63:0] v, input int n);
        for (int i = n; i > 0; i--) begin
            if (v[i-1])
                pred_partial[7 - pred_fill] = 1'b1;
            pred_fill++;
            if (pred_fill == 8) begin
                fresh_bytes.push_back(pred_partial);
                pred_partial = '0;
                pred_fill    = 0;
            end
        end
    endfunction

    function void put_ue(input logic [63:0] code);
        logic [63:0] v;
        int          len;
        v   = code + 64'd1;
        len = 0;
        for (int b = 63; b >= 0; b--)
            if (v[b] && len == 0)
                len = b + 1;
        put_bits(v, 2 * len - 1);
    endfunction

    function void pack_command(input bw_cmd_t c);
        logic [63:0] mag;
        int          nb;
        out_byte_t   ob;
        fresh_bytes.delete();
        nb = 0;
        case (c.op)
            CMD_BITS:
                put_bits(c.operand, (c.nbits > 7'd64) ? 64 : int'(c.nbits));
            CMD_UE:
                if (c.operand[63])
                    put_ue(64'd0);
                else
                    put_ue((c.operand > UE_MAX) ? UE_MAX : c.operand);
            CMD_SE:
                if (!c.operand[63]) begin
                    mag = (c.operand > SE_MAX) ? SE_MAX : c.operand;
                    put_ue((mag == 64'd0) ? 64'd0 : 2 * mag - 64'd1);
                end else begin
                    mag = ~c.operand + 64'd1;
                    if (mag > SE_MAX)
                        mag = SE_MAX;
                    put_ue(2 * mag);
                end
            CMD_BYTE:
                put_bits({56'd0, c.operand[7:0]}, 8);
            CMD_WORD2, CMD_WORD4, CMD_WORD8:
            begin
                nb = (c.op == CMD_WORD2) ? 2 : (c.op == CMD_WORD4) ? 4 : 8;
                for (int i = 0; i < nb; i++)
                    put_bits({56'd0, c.operand[8 * (cfg_order ? nb - 1 - i : i) +: 8]}, 8);
            end
            default:
                if (pred_fill != 0)
                    put_bits(64'd0, 8 - pred_fill);
        endcase
        foreach (fresh_bytes[k]) begin
            ob.data    = fresh_bytes[k];
            ob.is_last = (k == fresh_bytes.size() - 1);
            expected_bytes.push_back(ob);
        end
    endfunction

    // accept and predict at the rising edge
    always @(posedge clk) begin
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            pack_command(drv_cmd);
    end

    // driver: hold a stalled request, otherwise offer the next one or idle
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && !in_fire)) begin
            if (pending_cmds.size() != 0 && (no_idle || $urandom_range(0, 99) >= 19)) begin
                drv_cmd = pending_cmds.pop_front();
                command   <= drv_cmd.op;
                value     <= drv_cmd.operand;
                bit_count <= drv_cmd.nbits;
                in_valid  <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus a long hold-off when the test requests one
    always @(negedge clk) begin
        if (rx_hold_reqs != rx_hold_served) begin
            rx_hold_served = rx_hold_reqs;
            hold_left      = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !no_idle && ($urandom_range(0, 99) < 19);
        end
    end

    // monitor
    always @(posedge clk) begin
        out_byte_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected byte: out_byte=%h last_of_run=%b", out_byte, last_of_run);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data) begin
                    $error("out_byte: expected %h, got %h", want.data, out_byte);
                    errors++;
                end
                if (last_of_run !== want.is_last) begin
                    $error("last_of_run: expected %b, got %b", want.is_last, last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function void queue_cmd(input egbw_cmd_t op, input logic [63:0] operand,
                            input logic [6:0] nbits);
        bw_cmd_t c;
        c.op      = op;
        c.operand = operand;
        c.nbits   = nbits;
        pending_cmds.push_back(c);
    endfunction

    function logic [63:0] rand_operand();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: r = 64'($urandom_range(0, 300));
            1: r = -64'($urandom_range(1, 300));
            2: r = UE_MAX - 64'd2 + 64'($urandom_range(0, 4));
            3:
            begin
                // around the signed clamp, either sign
                r = SE_MAX - 64'd1 + 64'($urandom_range(0, 3));
                if ($urandom_range(0, 1) != 0)
                    r = -r;
            end
            4: case ($urandom_range(0, 3))
                   0: r = 64'h8000_0000_0000_0000;
                   1: r = 64'h7FFF_FFFF_FFFF_FFFF;
                   2: r = '1;
                   default: r = '0;
               endcase
            5: r = r >> $urandom_range(0, 63);
            default: ;
        endcase
        return r;
    endfunction

    function void queue_random(input int n);
        logic [6:0] nb;
        repeat (n) begin
            nb = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 64))
                                              : 7'($urandom_range(65, 127));
            queue_cmd(egbw_cmd_t'($urandom_range(0, 7)), rand_operand(), nb);
        end
    endfunction

    // wait for every request to be taken and every byte to arrive, then let the pipe empty
    task settle();
        while (pending_cmds.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task cfg_write(input logic order);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_WORD_ORDER);
        pwdata  <= {31'd0, order};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cfg_order = order;
        // read back
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        if (rd[0] !== order) begin
            $error("word_order: expected %b, got %b", order, rd[0]);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed: field extremes, clamps and alignment corners, little endian
        queue_cmd(CMD_BITS,  '1, 7'd0);
        queue_cmd(CMD_ALIGN, '0, 7'd0);
        queue_cmd(CMD_BITS,  64'd1, 7'd1);
        queue_cmd(CMD_ALIGN, '1, 7'd127);
        queue_cmd(CMD_BITS,  64'h7F, 7'd7);
        queue_cmd(CMD_BITS,  64'hA5C3_0F96_5A3C_F069, 7'd64);
        queue_cmd(CMD_BITS,  '1, 7'd127);
        queue_cmd(CMD_BITS,  64'h0123_4567_89AB_CDEF, 7'd65);
        queue_cmd(CMD_UE,    64'd0, 7'd0);
        queue_cmd(CMD_UE,    '1, 7'd0);
        queue_cmd(CMD_UE,    UE_MAX, 7'd0);
        queue_cmd(CMD_UE,    UE_MAX + 64'd1, 7'd0);
        queue_cmd(CMD_UE,    64'h7FFF_FFFF_FFFF_FFFF, 7'd0);
        queue_cmd(CMD_SE,    64'd0, 7'd0);
        queue_cmd(CMD_SE,    64'd1, 7'd0);
        queue_cmd(CMD_SE,    '1, 7'd0);
        queue_cmd(CMD_SE,    SE_MAX, 7'd0);
        queue_cmd(CMD_SE,    SE_MAX + 64'd1, 7'd0);
        queue_cmd(CMD_SE,    -SE_MAX, 7'd0);
        queue_cmd(CMD_SE,    64'h8000_0000_0000_0000, 7'd0);
        queue_cmd(CMD_BYTE,  64'hFFFF_FFFF_FFFF_FF5A, 7'd3);
        queue_cmd(CMD_WORD2, 64'h0123_4567_89AB_CDEF, 7'd0);
        queue_cmd(CMD_WORD4, 64'h0123_4567_89AB_CDEF, 7'd0);
        queue_cmd(CMD_WORD8, 64'h0123_4567_89AB_CDEF, 7'd0);
        queue_cmd(CMD_ALIGN, '0, 7'd0);
        settle();

        // big endian, with the receiver held off long enough to back up the input
        cfg_write(1'b1);
        @(posedge clk);
        rx_hold_reqs++;
        queue_cmd(CMD_WORD8, 64'h0123_4567_89AB_CDEF, 7'd0);
        queue_random(150);
        settle();

        // little endian, no idling on either side
        cfg_write(1'b0);
        no_idle = 1'b1;
        queue_random(150);
        settle();
        no_idle = 1'b0;

        cfg_write(1'b1);
        queue_random(135);
        settle();

        if (expected_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", expected_bytes.size());
            errors++;
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
